// ===== rtl/lpnf_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lpnf_pkg
// Shared constants, codes and types of the neighbor fill pass.
// ---------------------------------------------------------------------------
package lpnf_pkg;

	localparam int MAX_WIDTH    = 2048;
	localparam int CHANNEL_BITS = 16;

	// Column address, line width count and pending count widths
	localparam int ADDR_W = $clog2(MAX_WIDTH);
	localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
	localparam int PEND_W = $clog2(MAX_WIDTH + 2);
	localparam int ROW_W  = 16;
	localparam int BANKS  = 4;

	// Luma: 0.29891, 0.58661, 0.11448 scaled by 2^16, threshold 0.25
	localparam int LUMA_W = CHANNEL_BITS + 16;
	localparam int KEY_W  = CHANNEL_BITS + 14;
	localparam logic [16:0] LUMA_R = 17'd19589;
	localparam logic [16:0] LUMA_G = 17'd38444;
	localparam logic [16:0] LUMA_B = 17'd7503;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = (CHANNEL_BITS > 16) ? CHANNEL_BITS : 16;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PASS_MODE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_RED     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_GREEN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_BLUE    = 3'd5;

	// Alpha classes, pass modes, item kinds
	localparam logic [1:0] CLS_CLEAR  = 2'd0;
	localparam logic [1:0] CLS_SOURCE = 2'd1;
	localparam logic [1:0] CLS_TARGET = 2'd2;
	localparam logic [1:0] CLS_UNUSED = 2'd3;
	localparam logic [1:0] MODE_ORTHO = 2'd0;
	localparam logic [1:0] MODE_DIAG  = 2'd1;
	localparam logic [1:0] MODE_FILL  = 2'd2;
	localparam logic       REQ_PIXEL  = 1'b0;
	localparam logic       REQ_DRAIN  = 1'b1;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] r;
		logic [CHANNEL_BITS-1:0] g;
		logic [CHANNEL_BITS-1:0] b;
		logic [1:0]              cls;
	} pix_t;

	// One window column: top, middle, bottom (index 0..2), clamped at load
	typedef struct packed {
		pix_t [2:0]             p;
		logic [2:0]             ok;
		logic [2:0][KEY_W-1:0]  key;
	} col_t;

	// Emission info that travels with a column load
	typedef struct packed {
		logic load;
		logic emit;
		logic left;
		logic right;
		logic last;
	} info_t;

	// Controller request to the line store
	typedef struct packed {
		info_t                  info;
		logic                   wr_en;
		logic [1:0]             wr_bank;
		logic [ADDR_W-1:0]      wr_addr;
		logic [ADDR_W-1:0]      rd_addr;
		logic [2:0][1:0]        bank;
		logic [2:0]             use_in;
	} ld_t;

endpackage
`default_nettype wire

// ===== rtl/lpnf_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lpnf_if
// Valid/ready channels for pixel items in and result items out.
// ---------------------------------------------------------------------------
interface lpnf_pix_if;
	logic                              valid;
	logic                              ready;
	logic                              req_type;
	logic [lpnf_pkg::CHANNEL_BITS-1:0] pix_red;
	logic [lpnf_pkg::CHANNEL_BITS-1:0] pix_green;
	logic [lpnf_pkg::CHANNEL_BITS-1:0] pix_blue;
	logic [1:0]                        alpha_class;

	modport source(output valid, req_type, pix_red, pix_green, pix_blue, alpha_class,
		input ready);
	modport sink(input valid, req_type, pix_red, pix_green, pix_blue, alpha_class,
		output ready);
endinterface

interface lpnf_res_if;
	logic                              valid;
	logic                              ready;
	logic [lpnf_pkg::CHANNEL_BITS-1:0] out_red;
	logic [lpnf_pkg::CHANNEL_BITS-1:0] out_green;
	logic [lpnf_pkg::CHANNEL_BITS-1:0] out_blue;
	logic [1:0]                        out_class;
	logic                              replaced;
	logic                              frame_end;

	modport source(output valid, out_red, out_green, out_blue, out_class, replaced,
		frame_end, input ready);
	modport sink(input valid, out_red, out_green, out_blue, out_class, replaced,
		frame_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/lpnf_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lpnf_ctrl
// Raster counters: input position, output position, pending count and the
// choice of which column to load and which pixel to emit per item.
// ---------------------------------------------------------------------------
module lpnf_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic                          req_type,
	input  wire logic [11:0]                   cfg_width,
	input  wire logic [lpnf_pkg::ROW_W-1:0]    cfg_height,
	output lpnf_pkg::ld_t                      ld
);

	logic [lpnf_pkg::ADDR_W-1:0] cx_q, ox_q;
	logic [lpnf_pkg::ROW_W-1:0]  cy_q, oy_q;
	logic [lpnf_pkg::PEND_W-1:0] pend_q;
	logic [lpnf_pkg::WCNT_W-1:0] lat_w_q;
	logic [lpnf_pkg::ROW_W-1:0]  lat_h_q;
	logic                        full_q;

	logic [lpnf_pkg::ADDR_W-1:0] cx_n, ox_n, qx;
	logic [lpnf_pkg::ROW_W-1:0]  cy_n, oy_n, qy, oy_c;
	logic [lpnf_pkg::PEND_W-1:0] pend_n;
	logic [lpnf_pkg::WCNT_W-1:0] lat_w_n, eff_w, w, cx_inc, ox_inc;
	logic [lpnf_pkg::ROW_W-1:0]  lat_h_n, eff_h, h;
	logic                        full_n, start, is_pix, is_drain, last;
	logic [lpnf_pkg::ADDR_W-1:0] ox_c;
	logic [2:0][lpnf_pkg::ROW_W-1:0] rows;

	// Decide write, column load and emission for the accepted item
	always_comb begin
		start    = (cx_q == '0) && (cy_q == '0) && (pend_q == '0);
		is_pix   = accept && (req_type == lpnf_pkg::REQ_PIXEL) && !full_q;
		is_drain = accept && (req_type == lpnf_pkg::REQ_DRAIN) && full_q && (pend_q != '0);
		if (cfg_width == 12'd0)
			eff_w = lpnf_pkg::WCNT_W'(1);
		else if (32'(cfg_width) > lpnf_pkg::MAX_WIDTH)
			eff_w = lpnf_pkg::WCNT_W'(lpnf_pkg::MAX_WIDTH);
		else
			eff_w = lpnf_pkg::WCNT_W'(cfg_width);
		eff_h = (cfg_height == '0) ? lpnf_pkg::ROW_W'(1) : cfg_height;

		lat_w_n = lat_w_q;
		lat_h_n = lat_h_q;
		ox_c    = ox_q;
		oy_c    = oy_q;
		if (is_pix && start) begin
			lat_w_n = eff_w;
			lat_h_n = eff_h;
			ox_c    = '0;
			oy_c    = '0;
		end
		w = lat_w_n;
		h = lat_h_n;

		cx_n   = cx_q;
		cy_n   = cy_q;
		ox_n   = ox_c;
		oy_n   = oy_c;
		pend_n = pend_q;
		full_n = full_q;
		ld     = '0;
		qx     = ox_c;
		qy     = oy_c;
		cx_inc = lpnf_pkg::WCNT_W'(cx_q) + lpnf_pkg::WCNT_W'(1);
		ox_inc = lpnf_pkg::WCNT_W'(ox_c) + lpnf_pkg::WCNT_W'(1);

		// Pixel item: store it, advance the input position
		if (is_pix) begin
			ld.wr_en   = 1'b1;
			ld.wr_bank = cy_q[1:0];
			ld.wr_addr = cx_q;
			pend_n     = pend_q + lpnf_pkg::PEND_W'(1);
			if (cx_inc >= w) begin
				cx_n = '0;
				cy_n = cy_q + lpnf_pkg::ROW_W'(1);
				if (cy_n >= h)
					full_n = 1'b1;
			end else begin
				cx_n = cx_inc[lpnf_pkg::ADDR_W-1:0];
			end
			if (cy_q != '0) begin
				ld.info.load = 1'b1;
				qx           = cx_q;
				qy           = cy_q - lpnf_pkg::ROW_W'(1);
			end else if ((h == lpnf_pkg::ROW_W'(1)) && (cx_inc == w)) begin
				// single line: seed the window with the first column
				ld.info.load = 1'b1;
				qx           = '0;
				qy           = '0;
			end
			ld.info.emit = (pend_n > (lpnf_pkg::PEND_W'(w) + lpnf_pkg::PEND_W'(1)));
		end

		// Drain item: load the column after the one being emitted
		if (is_drain) begin
			ld.info.emit = 1'b1;
			ld.info.load = 1'b1;
			if (ox_inc >= w) begin
				qx = '0;
				qy = oy_c + lpnf_pkg::ROW_W'(1);
			end else begin
				qx = ox_inc[lpnf_pkg::ADDR_W-1:0];
				qy = oy_c;
			end
		end

		// Emission: advance the output position, restart after the last pixel
		last          = (ox_inc == w) && (oy_c == h - lpnf_pkg::ROW_W'(1));
		ld.info.left  = (ox_c == '0);
		ld.info.right = (ox_inc == w);
		ld.info.last  = last;
		if (ld.info.emit) begin
			if (last) begin
				cx_n   = '0;
				cy_n   = '0;
				ox_n   = '0;
				oy_n   = '0;
				pend_n = '0;
				full_n = 1'b0;
			end else begin
				pend_n = pend_n - lpnf_pkg::PEND_W'(1);
				if (ox_inc >= w) begin
					ox_n = '0;
					oy_n = oy_c + lpnf_pkg::ROW_W'(1);
				end else begin
					ox_n = ox_inc[lpnf_pkg::ADDR_W-1:0];
				end
			end
		end

		// Rows of the loaded column, clamped at the frame edges
		rows[0] = (qy == '0) ? qy : qy - lpnf_pkg::ROW_W'(1);
		rows[1] = qy;
		rows[2] = (qy >= h - lpnf_pkg::ROW_W'(1)) ? qy : qy + lpnf_pkg::ROW_W'(1);
		ld.rd_addr = qx;
		for (int k = 0; k < 3; k++) begin
			ld.bank[k]   = rows[k][1:0];
			ld.use_in[k] = is_pix && (rows[k] == cy_q) && (qx == cx_q);
		end
	end

	// Hold counters between items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q    <= '0;
			cy_q    <= '0;
			ox_q    <= '0;
			oy_q    <= '0;
			pend_q  <= '0;
			full_q  <= 1'b0;
			lat_w_q <= lpnf_pkg::WCNT_W'(lpnf_pkg::MAX_WIDTH);
			lat_h_q <= lpnf_pkg::ROW_W'(1080);
		end else if (accept) begin
			cx_q    <= cx_n;
			cy_q    <= cy_n;
			ox_q    <= ox_n;
			oy_q    <= oy_n;
			pend_q  <= pend_n;
			full_q  <= full_n;
			lat_w_q <= lat_w_n;
			lat_h_q <= lat_h_n;
		end
	end

`ifndef SYNTHESIS
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= lpnf_pkg::PEND_W'(lat_w_q) + lpnf_pkg::PEND_W'(1))
		else $error("pending count above line width plus one");
	a_full_pending: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> (pend_q != '0))
		else $error("frame complete with nothing pending");
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		lpnf_pkg::WCNT_W'(cx_q) < lat_w_q)
		else $error("input column beyond latched width");
	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		ld.info.emit |-> ld.info.load)
		else $error("emission without a column load");
`endif

endmodule
`default_nettype wire

// ===== rtl/lpnf_store.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lpnf_store
// Four line banks, column assembly with bypass of the incoming pixel, and
// luma of each column pixel.
// ---------------------------------------------------------------------------
module lpnf_store (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           adv,
	input  wire lpnf_pkg::ld_t  ld,
	input  wire lpnf_pkg::pix_t in_pix,
	output lpnf_pkg::info_t     info_s2,
	output lpnf_pkg::col_t      col_s2
);

	lpnf_pkg::pix_t             rd_s1 [lpnf_pkg::BANKS];
	lpnf_pkg::info_t            info_s1;
	logic [2:0][1:0]            bank_s1;
	logic [2:0]                 use_in_s1;
	lpnf_pkg::pix_t             pix_s1;
	lpnf_pkg::col_t             col_c;
	logic [lpnf_pkg::LUMA_W-1:0] luma [3];

	// Line banks: one write, one registered read per bank
	for (genvar b = 0; b < lpnf_pkg::BANKS; b++) begin : g_bank
		lpnf_pkg::pix_t line_mem [lpnf_pkg::MAX_WIDTH];

		always_ff @(posedge clk) begin
			if (ld.wr_en && (ld.wr_bank == 2'(b)))
				line_mem[ld.wr_addr] <= in_pix;
			if (adv)
				rd_s1[b] <= line_mem[ld.rd_addr];
		end
	end

	// Carry the request along with the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			info_s1 <= '0;
		else if (adv)
			info_s1 <= ld.info;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bank_s1   <= ld.bank;
			use_in_s1 <= ld.use_in;
			pix_s1    <= in_pix;
		end
	end

	// Assemble the column and grade each pixel
	always_comb begin
		col_c = '0;
		for (int k = 0; k < 3; k++) begin
			col_c.p[k] = use_in_s1[k] ? pix_s1 : rd_s1[bank_s1[k]];
			luma[k] = lpnf_pkg::LUMA_W'(lpnf_pkg::LUMA_R) * lpnf_pkg::LUMA_W'(col_c.p[k].r)
				+ lpnf_pkg::LUMA_W'(lpnf_pkg::LUMA_G) * lpnf_pkg::LUMA_W'(col_c.p[k].g)
				+ lpnf_pkg::LUMA_W'(lpnf_pkg::LUMA_B) * lpnf_pkg::LUMA_W'(col_c.p[k].b);
			col_c.key[k] = luma[k][lpnf_pkg::KEY_W-1:0];
			col_c.ok[k]  = (col_c.p[k].cls == lpnf_pkg::CLS_SOURCE)
				&& (luma[k][lpnf_pkg::LUMA_W-1:lpnf_pkg::KEY_W] == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			info_s2 <= '0;
		else if (adv)
			info_s2 <= info_s1;
	end

	always_ff @(posedge clk) begin
		if (adv)
			col_s2 <= col_c;
	end

endmodule
`default_nettype wire

// ===== rtl/lpnf_cell.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lpnf_cell
// One window column; takes its neighbor's column on each load.
// ---------------------------------------------------------------------------
module lpnf_cell (
	input  wire logic           clk,
	input  wire logic           shift,
	input  wire lpnf_pkg::col_t col_in,
	output lpnf_pkg::col_t      col_q
);

	// Advance the column along the chain
	always_ff @(posedge clk) begin
		if (shift)
			col_q <= col_in;
	end

endmodule
`default_nettype wire

// ===== rtl/line_pixel_neighbor_fill_pass.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// line_pixel_neighbor_fill_pass
// One neighbor fill pass over a raster frame, one item per unstalled clock.
// ---------------------------------------------------------------------------
// Usage:
//   pixels  : valid/ready item channel; req_type 0 is a pixel, 1 a drain item.
//   results : valid/ready item channel with the filled pixel and flags.
//   cfg_*   : write port; write registers only while the block is idle.
// A pixel's result is caused by the item that arrives one line plus one
// pixel after it; the last line plus one pixel of a frame is pushed out by
// drain items, one result per drain. From the causing item's acceptance the
// result passes the bank read at the accepting edge, then column luma, the
// window shift and selection into the output register on its way to results.
// Throughput is one item per cycle, set by the single write and read port of
// each line bank and the one-column-per-item window shift, barring stalls.
// Reset clears all counters; frame geometry is latched at a frame's first
// pixel. When results stalls, the pipeline keeps taking items until an
// emitting item waits behind the unread result, then holds every stage.
// ---------------------------------------------------------------------------
module line_pixel_neighbor_fill_pass (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	lpnf_pix_if.sink                                pixels,
	lpnf_res_if.source                              results,
	input  wire logic                               cfg_we,
	input  wire logic [lpnf_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [lpnf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	logic [11:0]                       width_q;
	logic [lpnf_pkg::ROW_W-1:0]        height_q;
	logic [1:0]                        mode_q;
	logic [lpnf_pkg::CHANNEL_BITS-1:0] fill_r_q, fill_g_q, fill_b_q;

	logic             adv, accept;
	lpnf_pkg::pix_t   in_pix;
	lpnf_pkg::ld_t    ld;
	lpnf_pkg::info_t  info_s2, info_s3;
	lpnf_pkg::col_t   col_s2;
	lpnf_pkg::col_t   win [3];
	lpnf_pkg::col_t   lcol, rcol;

	lpnf_pkg::pix_t [3:0]              cand;
	logic [3:0]                        cand_ok;
	logic [3:0][lpnf_pkg::KEY_W-1:0]   cand_key;
	logic [lpnf_pkg::KEY_W:0]          best;
	lpnf_pkg::pix_t                    res, ctr;
	logic                              repl;

	lpnf_pkg::pix_t out_pix_q;
	logic           out_valid_q, repl_q, end_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 12'd2048;
			height_q <= lpnf_pkg::ROW_W'(1080);
			mode_q   <= lpnf_pkg::MODE_ORTHO;
			fill_r_q <= '0;
			fill_g_q <= '0;
			fill_b_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				lpnf_pkg::CFG_FRAME_WIDTH:  width_q  <= cfg_wdata[11:0];
				lpnf_pkg::CFG_FRAME_HEIGHT: height_q <= cfg_wdata[lpnf_pkg::ROW_W-1:0];
				lpnf_pkg::CFG_PASS_MODE:    mode_q   <= cfg_wdata[1:0];
				lpnf_pkg::CFG_FILL_RED:     fill_r_q <= cfg_wdata[lpnf_pkg::CHANNEL_BITS-1:0];
				lpnf_pkg::CFG_FILL_GREEN:   fill_g_q <= cfg_wdata[lpnf_pkg::CHANNEL_BITS-1:0];
				lpnf_pkg::CFG_FILL_BLUE:    fill_b_q <= cfg_wdata[lpnf_pkg::CHANNEL_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Stall only when an emission meets a result still waiting
	assign adv          = !(info_s3.emit && out_valid_q && !results.ready);
	assign pixels.ready = adv;
	assign accept       = pixels.valid && adv;
	assign in_pix       = '{r: pixels.pix_red, g: pixels.pix_green, b: pixels.pix_blue,
		cls: pixels.alpha_class};

	lpnf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.req_type   (pixels.req_type),
		.cfg_width  (width_q),
		.cfg_height (height_q),
		.ld         (ld)
	);

	lpnf_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ld      (ld),
		.in_pix  (in_pix),
		.info_s2 (info_s2),
		.col_s2  (col_s2)
	);

	// Window: left, center, right columns as a chain of cells
	for (genvar i = 0; i < 3; i++) begin : g_win
		if (i == 2) begin : g_head
			lpnf_cell u_cell (
				.clk    (clk),
				.shift  (adv && info_s2.load),
				.col_in (col_s2),
				.col_q  (win[i])
			);
		end else begin : g_body
			lpnf_cell u_cell (
				.clk    (clk),
				.shift  (adv && info_s2.load),
				.col_in (win[i+1]),
				.col_q  (win[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			info_s3 <= '0;
		else if (adv)
			info_s3 <= info_s2;
	end

	// Pick darkest qualifying source neighbor, first on a tie, or fill color
	always_comb begin
		lcol = info_s3.left ? win[1] : win[0];
		rcol = info_s3.right ? win[1] : win[2];
		ctr  = win[1].p[1];
		if (mode_q == lpnf_pkg::MODE_DIAG) begin
			cand[0] = lcol.p[0]; cand_ok[0] = lcol.ok[0]; cand_key[0] = lcol.key[0];
			cand[1] = rcol.p[0]; cand_ok[1] = rcol.ok[0]; cand_key[1] = rcol.key[0];
			cand[2] = lcol.p[2]; cand_ok[2] = lcol.ok[2]; cand_key[2] = lcol.key[2];
			cand[3] = rcol.p[2]; cand_ok[3] = rcol.ok[2]; cand_key[3] = rcol.key[2];
		end else begin
			cand[0] = win[1].p[0]; cand_ok[0] = win[1].ok[0]; cand_key[0] = win[1].key[0];
			cand[1] = rcol.p[1];   cand_ok[1] = rcol.ok[1];   cand_key[1] = rcol.key[1];
			cand[2] = win[1].p[2]; cand_ok[2] = win[1].ok[2]; cand_key[2] = win[1].key[2];
			cand[3] = lcol.p[1];   cand_ok[3] = lcol.ok[1];   cand_key[3] = lcol.key[1];
		end

		res  = ctr;
		repl = 1'b0;
		best = {1'b1, {lpnf_pkg::KEY_W{1'b0}}};
		if (ctr.cls == lpnf_pkg::CLS_UNUSED)
			res.cls = lpnf_pkg::CLS_CLEAR;
		if (ctr.cls == lpnf_pkg::CLS_TARGET) begin
			if (mode_q == lpnf_pkg::MODE_FILL) begin
				res  = '{r: fill_r_q, g: fill_g_q, b: fill_b_q, cls: lpnf_pkg::CLS_SOURCE};
				repl = 1'b1;
			end else begin
				for (int i = 0; i < 4; i++) begin
					if (cand_ok[i] && ({1'b0, cand_key[i]} < best)) begin
						best = {1'b0, cand_key[i]};
						res  = cand[i];
						repl = 1'b1;
					end
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && info_s3.emit) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && info_s3.emit) begin
			out_pix_q <= res;
			repl_q    <= repl;
			end_q     <= info_s3.last;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.out_red   = out_pix_q.r;
	assign results.out_green = out_pix_q.g;
	assign results.out_blue  = out_pix_q.b;
	assign results.out_class = out_pix_q.cls;
	assign results.replaced  = repl_q;
	assign results.frame_end = end_q;

`ifndef SYNTHESIS
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !results.ready && info_s3.emit) |-> !pixels.ready)
		else $error("item taken while an emission is blocked");
	a_emit_center_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		info_s3.emit |-> $past(info_s2.load || !adv))
		else $error("emission without a fresh window column");
	a_repl_target: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && info_s3.emit && repl) |=> (results.out_class == lpnf_pkg::CLS_SOURCE))
		else $error("replaced pixel not marked source");
`endif

endmodule
`default_nettype wire
